// ===== rtl/rsum_pkg.sv =====
// rsum_pkg: widths, fixed-point constants and the quarter-wave cosine table
// for the streaming rastrigin objective core; no dependencies
package rsum_pkg;

  localparam int COORD_W        = 16;
  localparam int SUM_W          = 28;
  localparam int S_TDATA_W      = 16;
  localparam int M_TDATA_W      = 32;
  localparam int FRAC_BITS      = 12;
  localparam int COS_TABLE_BITS = 10;
  localparam int COS_N          = 1 << COS_TABLE_BITS;
  localparam int QUARTER_N      = COS_N / 4;
  localparam int QIDX_W         = COS_TABLE_BITS - 2;
  localparam int COS_W          = 15;
  localparam int ONE_Q14        = 16384;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // phase index from fraction bits
  localparam int IDX_SHR = (FRAC_BITS > COS_TABLE_BITS) ? FRAC_BITS - COS_TABLE_BITS : 0;
  localparam int IDX_SHL = (FRAC_BITS > COS_TABLE_BITS) ? 0 : COS_TABLE_BITS - FRAC_BITS;
  localparam int IDX_RND = (IDX_SHR > 0) ? (1 << (IDX_SHR - 1)) : 0;

  // penalty rescale from q14 to FRAC_BITS
  localparam int PEN_SHR = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
  localparam int PEN_SHL = (FRAC_BITS > 14) ? FRAC_BITS - 14 : 0;
  localparam int PEN_RND = (PEN_SHR > 0) ? (1 << (PEN_SHR - 1)) : 0;
  localparam int D10_W   = 21;
  localparam int PEN_W   = D10_W + PEN_SHL;

  localparam int SQ_W    = 2 * COORD_W + 1 - FRAC_BITS;
  localparam int TOT_A   = (SQ_W > PEN_W) ? SQ_W : PEN_W;
  localparam int TOT_W   = ((TOT_A > SUM_W) ? TOT_A : SUM_W) + 2;

  typedef logic [QUARTER_N-1:0][COS_W-1:0] cos_quarter_t;

  // cos(2*pi*u/N) in q1.14 for u in [0, N/4], truncated taylor series in q30
  function automatic logic [COS_W-1:0] quarter_cos(input int unsigned u);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    longint      acc;
    a    = (64'(u) * 64'd6746518852) >> COS_TABLE_BITS;
    a2   = (a * a) >> 30;
    term = 64'd1 << 30;
    acc  = 64'sd1 << 30;
    term = ((term * a2) >> 30) / 64'd2;   acc = acc - longint'(term);
    term = ((term * a2) >> 30) / 64'd12;  acc = acc + longint'(term);
    term = ((term * a2) >> 30) / 64'd30;  acc = acc - longint'(term);
    term = ((term * a2) >> 30) / 64'd56;  acc = acc + longint'(term);
    term = ((term * a2) >> 30) / 64'd90;  acc = acc - longint'(term);
    term = ((term * a2) >> 30) / 64'd132; acc = acc + longint'(term);
    term = ((term * a2) >> 30) / 64'd182; acc = acc - longint'(term);
    if (acc < 0) acc = 0;
    acc = (acc + 64'sd32768) >>> 16;
    if (acc > 64'sd16384) acc = 64'sd16384;
    return COS_W'(acc);
  endfunction

  function automatic cos_quarter_t build_quarter();
    cos_quarter_t t;
    for (int i = 0; i < QUARTER_N; i++) begin
      t[i] = quarter_cos(i);
    end
    return t;
  endfunction

  localparam cos_quarter_t     COS_QUARTER     = build_quarter();
  localparam logic [COS_W-1:0] COS_QUARTER_END = quarter_cos(QUARTER_N);

endpackage

// ===== rtl/rastrigin_sum_core.sv =====
// rastrigin_sum_core: streaming rastrigin objective, x*x + 10 - 10*cos(2*pi*x)
// accumulated per element, sum emitted on the last element
// depends on rsum_pkg (widths, shift constants, quarter-wave cosine table)
//
//  channel | handshake         | payload
//  --------+-------------------+---------------------------------------------
//  s_*     | s_tvalid/s_tready | s_tdata = coordinate, s_tlast = last_element
//  m_*     | m_tvalid/m_tready | m_tdata = objective_value (zero padded)
//
// one element per cycle unless a stalled result holds it; each element is
// registered at the input, where the square, cosine table lookup and accumulate
// act on it; the result register takes the sum when the last element advances
// rst clears the input and result valids and the running sum
// a stalled result only holds the pipe when a further last element reaches it
module rastrigin_sum_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rsum_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] coordinate
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rsum_pkg::M_TDATA_W-1:0]  m_tdata    // [27:0] objective_value
);

  localparam int CTB = rsum_pkg::COS_TABLE_BITS;
  localparam int FB  = rsum_pkg::FRAC_BITS;
  localparam int CW  = rsum_pkg::COORD_W;

  localparam logic [CTB-1:0] HALF_IDX = CTB'(rsum_pkg::COS_N / 2);
  localparam logic [CTB-1:0] QTR_IDX  = CTB'(rsum_pkg::QUARTER_N);

  logic                          in_valid;
  logic [CW-1:0]                 in_coord;
  logic                          in_last;
  logic [rsum_pkg::SUM_W-1:0]    running_sum;
  logic [rsum_pkg::SUM_W-1:0]    out_value;
  logic                          advance;

  logic [CW-1:0]                 mag;
  logic [2*CW:0]                 sq_full;
  logic [rsum_pkg::SQ_W-1:0]     sq;
  logic [FB:0]                   frac_rnd;
  logic [FB+rsum_pkg::IDX_SHL:0] phase;
  logic [CTB-1:0]                idx;
  logic [CTB-1:0]                u;
  logic [CTB-1:0]                qsel;
  logic                          neg;
  logic [rsum_pkg::COS_W-1:0]    qv;
  logic [16:0]                   diff;
  logic [rsum_pkg::D10_W-1:0]    d10;
  logic [rsum_pkg::D10_W-1:0]    pen_shr;
  logic [rsum_pkg::PEN_W-1:0]    pen;
  logic [rsum_pkg::TOT_W-1:0]    total;
  logic [rsum_pkg::SUM_W-1:0]    sum_next;

  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tdata  = rsum_pkg::M_TDATA_W'(out_value);

  always_comb begin
    mag      = in_coord[CW-1] ? (CW'(0) - in_coord) : in_coord;
    sq_full  = (2*CW+1)'({CW'(0), mag} * {CW'(0), mag}) + (2*CW+1)'(1 << (FB - 1));
    sq       = rsum_pkg::SQ_W'(sq_full >> FB);

    frac_rnd = {1'b0, in_coord[FB-1:0]} + (FB+1)'(rsum_pkg::IDX_RND);
    phase    = ((FB + rsum_pkg::IDX_SHL + 1)'(frac_rnd) >> rsum_pkg::IDX_SHR)
               << rsum_pkg::IDX_SHL;
    idx      = phase[CTB-1:0];

    // fold the phase onto the first quarter wave
    u        = (idx <= HALF_IDX) ? idx : (CTB'(0) - idx);
    neg      = (u > QTR_IDX);
    qsel     = neg ? (HALF_IDX - u) : u;
    qv       = (qsel == QTR_IDX) ? rsum_pkg::COS_QUARTER_END
                                 : rsum_pkg::COS_QUARTER[qsel[rsum_pkg::QIDX_W-1:0]];
    diff     = neg ? (17'(rsum_pkg::ONE_Q14) + 17'(qv))
                   : (17'(rsum_pkg::ONE_Q14) - 17'(qv));
    d10      = rsum_pkg::D10_W'(diff) * rsum_pkg::D10_W'(10);
    pen_shr  = (d10 + rsum_pkg::D10_W'(rsum_pkg::PEN_RND)) >> rsum_pkg::PEN_SHR;
    pen      = rsum_pkg::PEN_W'(pen_shr) << rsum_pkg::PEN_SHL;

    total    = rsum_pkg::TOT_W'(running_sum) + rsum_pkg::TOT_W'(sq)
             + rsum_pkg::TOT_W'(pen);
    sum_next = (total > rsum_pkg::TOT_W'(rsum_pkg::SUM_MAX))
             ? rsum_pkg::SUM_MAX : total[rsum_pkg::SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_coord <= s_tdata[CW-1:0];
      in_last  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (advance) begin
      running_sum <= in_last ? '0 : sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_value <= sum_next;
    end
  end

endmodule

// ===== dv/testbench.sv =====
// testbench for rastrigin_sum_core: streams vectors of coordinates through the
// core and checks every emitted objective sum against an in-bench fixed-point
// predictor; depends on rsum_pkg and rtl/rastrigin_sum_core.sv
module testbench;

  localparam int PHASE_SHIFT = rsum_pkg::FRAC_BITS - rsum_pkg::COS_TABLE_BITS;
  localparam int PEN_SHIFT   = 14 - rsum_pkg::FRAC_BITS;
  localparam int RANDOM_ITEMS = 310;
  localparam int BIG_LEN     = 120;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic [rsum_pkg::COORD_W-1:0] coordinate;
    logic                         last_element;
  } element_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [rsum_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                           s_tlast = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [rsum_pkg::M_TDATA_W-1:0] m_tdata;

  element_t                   pending_elements[$];
  logic [rsum_pkg::SUM_W-1:0] expected_sums[$];
  int                         cos_lut[rsum_pkg::COS_N];
  logic [rsum_pkg::SUM_W-1:0] partial_sum;
  int                         accepted_count;
  int                         total_items;
  int                         failures;
  int                         cycle_count;
  element_t                   head;
  int                         burst_left;
  int                         gap_left;
  int                         hold_left;
  bit                         hold_done;
  int                         mode_left;
  int                         ready_mode;
  int                         toggle_phase;

  rastrigin_sum_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // cos(2*pi*step/N) in q1.14 from a truncated q30 taylor series
  function automatic int taylor_cos_q14(int unsigned step);
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] term;
    longint      acc;
    int          k;
    ang  = (64'(step) * 64'd6746518852) >> rsum_pkg::COS_TABLE_BITS;
    ang2 = (ang * ang) >> 30;
    term = 64'd1 << 30;
    acc  = longint'(1) << 30;
    for (k = 1; k <= 7; k++) begin
      term = ((term * ang2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    acc = (acc + 32768) >>> 16;
    if (acc > rsum_pkg::ONE_Q14) acc = rsum_pkg::ONE_Q14;
    return int'(acc);
  endfunction

  // adds one element's term to the running sum, queues the sum on the last one
  function automatic void accumulate_element(logic [rsum_pkg::COORD_W-1:0] raw, logic last);
    logic [16:0] mag;
    logic [63:0] sq;
    logic [63:0] pen;
    logic [63:0] total;
    int unsigned frac;
    int unsigned idx;
    int unsigned diff;
    mag   = raw[rsum_pkg::COORD_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    sq    = (64'(mag) * 64'(mag) + (64'd1 << (rsum_pkg::FRAC_BITS - 1)))
            >> rsum_pkg::FRAC_BITS;
    frac  = raw & ((1 << rsum_pkg::FRAC_BITS) - 1);
    idx   = ((frac + (1 << (PHASE_SHIFT - 1))) >> PHASE_SHIFT) & (rsum_pkg::COS_N - 1);
    diff  = (rsum_pkg::ONE_Q14 - cos_lut[idx]) * 10;
    pen   = (64'(diff) + (64'd1 << (PEN_SHIFT - 1))) >> PEN_SHIFT;
    total = 64'(partial_sum) + sq + pen;
    if (total > 64'(rsum_pkg::SUM_MAX)) total = 64'(rsum_pkg::SUM_MAX);
    if (last) begin
      expected_sums.push_back(total[rsum_pkg::SUM_W-1:0]);
      partial_sum = '0;
    end else begin
      partial_sum = total[rsum_pkg::SUM_W-1:0];
    end
  endfunction

  function automatic logic [rsum_pkg::COORD_W-1:0] random_coordinate();
    if ($urandom_range(0, 7) == 0) return rsum_pkg::COORD_W'($urandom());
    return rsum_pkg::COORD_W'(int'($urandom_range(0, 41944)) - 20972);
  endfunction

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        accumulate_element(s_tdata[rsum_pkg::COORD_W-1:0], s_tlast);
        accepted_count++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_elements.size() != 0) begin
          head = pending_elements.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= head.coordinate;
          s_tlast  <= head.last_element;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern that changes mode, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready     <= 1'b0;
      hold_left    = 0;
      hold_done    = 1'b0;
      mode_left    = 0;
      ready_mode   = 0;
      toggle_phase = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && accepted_count >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left  = $urandom_range(32, 128);
        ready_mode = $urandom_range(0, 4);
      end
      mode_left--;
      toggle_phase = toggle_phase ^ 1;
      case (ready_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 1) != 0);
        3: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= toggle_phase[0];
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result transaction, objective_value %0d",
               m_tdata[rsum_pkg::SUM_W-1:0]);
        failures++;
      end else begin
        if (m_tdata[rsum_pkg::SUM_W-1:0] !== expected_sums[0]) begin
          $error("objective_value mismatch: expected %0d, actual %0d",
                 expected_sums[0], m_tdata[rsum_pkg::SUM_W-1:0]);
          failures++;
        end
        void'(expected_sums.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rastrigin_sum_core verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    int unsigned u;
    int          n;
    int          len;
    int          j;
    logic [rsum_pkg::COORD_W-1:0] big;

    for (p = 0; p < rsum_pkg::COS_N; p++) begin
      u = (p <= rsum_pkg::COS_N / 2) ? p : rsum_pkg::COS_N - p;
      if (u <= rsum_pkg::COS_N / 4) cos_lut[p] = taylor_cos_q14(u);
      else cos_lut[p] = -taylor_cos_q14(rsum_pkg::COS_N / 2 - u);
    end
    partial_sum    = '0;
    accepted_count = 0;
    failures       = 0;
    cycle_count    = 0;

    // short and single-element vectors and field extremes
    pending_elements.push_back('{16'h0000, 1'b1});
    pending_elements.push_back('{16'sd20972, 1'b0});
    pending_elements.push_back('{-16'sd20972, 1'b0});
    pending_elements.push_back('{16'h7FFF, 1'b0});
    pending_elements.push_back('{16'h8000, 1'b0});
    pending_elements.push_back('{16'hFFFF, 1'b0});
    pending_elements.push_back('{16'h0001, 1'b0});
    pending_elements.push_back('{16'h0FFF, 1'b1});
    pending_elements.push_back('{16'h0800, 1'b1});
    pending_elements.push_back('{16'h0400, 1'b0});
    pending_elements.push_back('{16'h0C00, 1'b0});
    pending_elements.push_back('{16'h0002, 1'b0});
    pending_elements.push_back('{16'hF800, 1'b1});
    pending_elements.push_back('{16'hF3FF, 1'b1});
    pending_elements.push_back('{16'h5555, 1'b0});
    pending_elements.push_back('{16'hAAAA, 1'b1});

    // one long vector of large magnitudes
    for (j = 0; j < BIG_LEN; j++) begin
      big = rsum_pkg::COORD_W'($urandom_range(0, 16'h0FFF));
      big = big | (($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7000);
      pending_elements.push_back('{big, j == BIG_LEN - 1});
    end
    pending_elements.push_back('{16'h1000, 1'b1});

    n = 0;
    while (n < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
      for (j = 0; j < len; j++) begin
        pending_elements.push_back('{random_coordinate(), j == len - 1});
        n++;
      end
    end
    total_items = pending_elements.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_items) @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_sums.size() != 0) begin
      $error("%0d expected results never arrived", expected_sums.size());
      failures++;
    end
    if (failures == 0) begin
      $display("rastrigin_sum_core verification clean");
    end else begin
      $display("rastrigin_sum_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rsum_pkg.sv
rtl/rastrigin_sum_core.sv
dv/testbench.sv
